### design/scps_pkg.sv
// Shared types, constants and register codes for the spectrum column smoother.
package scps_pkg;

  // Default number of display columns.
  localparam int COLUMNS_DEF = 256;

  // Configuration port.
  localparam int CFG_DATA_W = 27;
  localparam int CFG_IDX_W  = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SMOOTH_ALPHA = 2'd0;
  localparam cfg_idx_t CFG_HOLD_DUR     = 2'd1;
  localparam cfg_idx_t CFG_DISP_HEIGHT  = 2'd2;

  localparam logic [7:0]  ALPHA_RST  = 8'd102;
  localparam logic [26:0] HOLD_RST   = 27'd2000000;
  localparam logic [9:0]  HEIGHT_RST = 10'd200;

  // Level saturation window, dB * 16.
  localparam logic signed [15:0] LVL_MIN_IN = -16'sd1600;
  localparam logic signed [15:0] LVL_MAX_IN = 16'sd320;

  // Peak value after reset (-200 dB).
  localparam logic signed [12:0] PEAK_RST = -13'sd3200;

  // Height scaling: floor((v + 1600) * H / 1920), 1920 = 128 * 15.
  // The divide by 15 is a reciprocal multiply, exact for dividends below 2^14.
  localparam logic signed [13:0] HGT_OFFSET  = 14'sd1600;
  localparam int                 SPAN_SHIFT  = 7;
  localparam logic [14:0]        RECIP_15    = 15'd17477;
  localparam int                 RECIP_SHIFT = 18;

  // One column entry of the state memory.
  typedef struct packed {
    logic signed [11:0] smooth;
    logic signed [12:0] peak;
    logic [31:0]        ptime;
  } col_word_t;

  typedef struct packed {
    logic [7:0]         column;
    logic signed [15:0] level_db_q4;
    logic [31:0]        now_us;
    logic               frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_column;
    logic signed [11:0] smoothed_db_q4;
    logic [9:0]         bar_height;
    logic [9:0]         peak_height;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MULT,
    ST_UPD,
    ST_HGT,
    ST_WAIT
  } state_t;

endpackage

### design/scps_col_ram.sv
// Per-column state memory: one write port, one read port, registered read data.
module scps_col_ram #(
  parameter int DEPTH = scps_pkg::COLUMNS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  scps_pkg::col_word_t      wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output scps_pkg::col_word_t      rdata
);

  scps_pkg::col_word_t mem [DEPTH];
  scps_pkg::col_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/scps_height.sv
// Two-stage level-to-pixel scaler: floor((v + 1600) * H / 1920), clamped to 0..H-1.
module scps_height (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [12:0] value,
  input  logic [9:0]         height,
  output logic               done,
  output logic [9:0]         result
);

  logic signed [13:0] n_full;
  logic [10:0]        n_pos;
  logic [20:0]        prod_a;
  logic [20:0]        prod_a_r;
  logic [13:0]        q_in;
  logic [28:0]        prod_b;
  logic [10:0]        quo_r;
  logic               va_r;
  logic               vb_r;
  logic               vb_nxt;
  logic [10:0]        h_max;

  assign n_full = {value[12], value} + scps_pkg::HGT_OFFSET;
  assign n_pos  = (n_full <= 14'sd0) ? 11'd0 : n_full[10:0];
  assign prod_a = 21'(n_pos) * 21'(height);

  // divide by 128, then by 15 through the reciprocal
  assign q_in   = prod_a_r[20:scps_pkg::SPAN_SHIFT];
  assign prod_b = 29'(q_in) * 29'(scps_pkg::RECIP_15);

  always_ff @(posedge clk) begin
    if (start) begin
      prod_a_r <= prod_a;
    end
    if (va_r) begin
      quo_r <= prod_b[28:scps_pkg::RECIP_SHIFT];
    end
  end

  always_comb begin
    vb_nxt = vb_r;
    if (va_r) begin
      vb_nxt = 1'b1;
    end else if (start) begin
      vb_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= start;
      vb_r <= vb_nxt;
    end
  end

  assign h_max = {1'b0, height} - 11'd1;

  always_comb begin
    if (height == 10'd0) begin
      result = 10'd0;
    end else if (quo_r > h_max) begin
      result = h_max[9:0];
    end else begin
      result = quo_r[9:0];
    end
  end

  assign done = vb_r;

endmodule

### design/spectrum_column_smooth_peak_hold_top.sv
// Top level of the spectrum column smoother with peak hold.
//
//  channel | ports                        | direction | handshake
//  --------+------------------------------+-----------+----------------------
//  input   | in_valid, in_ready, in_data  | in        | valid/ready, one bin
//  result  | out_valid, out_ready, out_data| out      | valid/ready, one result
//  config  | cfg_we, cfg_index, cfg_wdata | in        | write strobe, no wait
//
// Each request goes through these steps: accept with memory read, smoothing
// multiply, peak update with write-back, the height scalers, then the result load.
// Items are handled one at a time through the single state memory.
// After reset a clearing pass writes every column with in_ready low;
// configuration writes are taken during that pass.
// The result register lets the next request be accepted while a result
// waits; a stalled output holds the block only at its final step.
module spectrum_column_smooth_peak_hold_top #(
  parameter int COLUMNS = scps_pkg::COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  scps_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output scps_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  scps_pkg::cfg_idx_t              cfg_index,
  input  logic [scps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(COLUMNS);
  localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;

  scps_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic             primed_r, primed_nxt;

  // configuration registers
  logic [7:0]  alpha_r;
  logic [26:0] hold_r;
  logic [9:0]  height_r;

  // request accepted this cycle
  logic accept;

  // column and level clamping on the input side
  logic [CMP_W-1:0]   col_w;
  logic [CMP_W-1:0]   col_sat;
  logic signed [11:0] in_lvl;

  // captured request
  logic [IDX_W-1:0]   idx_r;
  logic [7:0]         col_r;
  logic signed [11:0] lvl_r;
  logic [31:0]        now_r;
  logic               last_r;

  // memory
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  scps_pkg::col_word_t ram_wdata;
  scps_pkg::col_word_t ram_rdata;

  // smoothing datapath
  logic signed [12:0] diff;
  logic signed [8:0]  alpha_s;
  logic signed [21:0] prod_full;
  logic signed [21:0] prod_r;
  logic signed [13:0] s_sum;
  logic signed [11:0] s_new;
  logic signed [12:0] s_ext;
  logic [31:0]        elapsed;
  logic               pk_take;
  logic signed [12:0] pk_new;
  logic [31:0]        t_new;
  logic signed [11:0] s_r;
  logic signed [12:0] pk_r;

  // height scalers and output
  logic               hgt_start;
  logic               bar_done, pk_done;
  logic [9:0]         bar_h, pk_h;
  logic               out_load;
  logic               out_valid_r, out_valid_nxt;
  scps_pkg::out_item_t out_data_r;

  assign in_ready = (state_r == scps_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= scps_pkg::ALPHA_RST;
      hold_r   <= scps_pkg::HOLD_RST;
      height_r <= scps_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scps_pkg::CFG_SMOOTH_ALPHA: alpha_r  <= cfg_wdata[7:0];
        scps_pkg::CFG_HOLD_DUR:     hold_r   <= cfg_wdata[26:0];
        scps_pkg::CFG_DISP_HEIGHT:  height_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // columns past the end land on the last column
  assign col_w   = CMP_W'(in_data.column);
  assign col_sat = (col_w > CMP_W'(COLUMNS - 1)) ? CMP_W'(COLUMNS - 1) : col_w;

  always_comb begin
    if (in_data.level_db_q4 < scps_pkg::LVL_MIN_IN) begin
      in_lvl = scps_pkg::LVL_MIN_IN[11:0];
    end else if (in_data.level_db_q4 > scps_pkg::LVL_MAX_IN) begin
      in_lvl = scps_pkg::LVL_MAX_IN[11:0];
    end else begin
      in_lvl = in_data.level_db_q4[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= col_sat[IDX_W-1:0];
      col_r  <= col_sat[7:0];
      lvl_r  <= in_lvl;
      now_r  <= in_data.now_us;
      last_r <= in_data.frame_last;
    end
  end

  scps_col_ram #(
    .DEPTH (COLUMNS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_sat[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // step toward the new level: alpha * (level - smoothed), Q0.8
  assign diff      = {lvl_r[11], lvl_r} - {ram_rdata.smooth[11], ram_rdata.smooth};
  assign alpha_s   = {1'b0, alpha_r};
  assign prod_full = diff * alpha_s;

  always_ff @(posedge clk) begin
    if (state_r == scps_pkg::ST_MULT) begin
      prod_r <= prod_full;
    end
  end

  // arithmetic shift right gives the floor of the divide by 256
  assign s_sum = {{2{ram_rdata.smooth[11]}}, ram_rdata.smooth} + prod_r[21:8];
  assign s_new = primed_r ? s_sum[11:0] : lvl_r;
  assign s_ext = {s_new[11], s_new};

  // hold expiry on the wrapped difference of the timer
  assign elapsed = now_r - ram_rdata.ptime;
  assign pk_take = (s_ext > ram_rdata.peak) || (elapsed > {5'b0, hold_r});
  assign pk_new  = pk_take ? s_ext : ram_rdata.peak;
  assign t_new   = pk_take ? now_r : ram_rdata.ptime;

  always_ff @(posedge clk) begin
    if (state_r == scps_pkg::ST_UPD) begin
      s_r  <= s_new;
      pk_r <= pk_new;
    end
  end

  // control
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    primed_nxt  = primed_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = '{smooth: s_new, peak: pk_new, ptime: t_new};
    hgt_start   = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      scps_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '{smooth: 12'sd0, peak: scps_pkg::PEAK_RST, ptime: 32'd0};
        if (clr_idx_r == IDX_W'(COLUMNS - 1)) begin
          state_nxt = scps_pkg::ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_W'(1);
        end
      end
      scps_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = scps_pkg::ST_MULT;
        end
      end
      scps_pkg::ST_MULT: begin
        state_nxt = scps_pkg::ST_UPD;
      end
      scps_pkg::ST_UPD: begin
        ram_we = 1'b1;
        if (last_r) begin
          primed_nxt = 1'b1;
        end
        state_nxt = scps_pkg::ST_HGT;
      end
      scps_pkg::ST_HGT: begin
        hgt_start = 1'b1;
        state_nxt = scps_pkg::ST_WAIT;
      end
      scps_pkg::ST_WAIT: begin
        if (bar_done && pk_done && (!out_valid_r || out_ready)) begin
          out_load  = 1'b1;
          state_nxt = scps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= scps_pkg::ST_CLEAR;
      clr_idx_r <= '0;
      primed_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      primed_r  <= primed_nxt;
    end
  end

  scps_height u_bar_hgt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hgt_start),
    .value  ({s_r[11], s_r}),
    .height (height_r),
    .done   (bar_done),
    .result (bar_h)
  );

  scps_height u_pk_hgt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hgt_start),
    .value  (pk_r),
    .height (height_r),
    .done   (pk_done),
    .result (pk_h)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= '{out_column: col_r, smoothed_db_q4: s_r,
                      bar_height: bar_h, peak_height: pk_h};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
